[rtl/bca_pkg.sv]
package bca_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CHUNKS   = 8192;
    localparam int DEF_CHUNK_BYTES  = 128;   // must be a power of two
    localparam int DEF_HEADER_BYTES = 16;

    // Bits per map word held in one memory entry
    localparam int WORD_BITS = 64;
    // Width of internal chunk index / count arithmetic
    localparam int IDX_W     = 24;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 21;
    localparam int START_W  = 13;
    localparam int LEN_W    = 14;
    localparam int STATUS_W = 2;
    localparam int HEAP_W   = 14;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

endpackage

[rtl/bca_ram.sv]
module bca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[rtl/bitmap_chunk_allocator_core.sv]
// Bitmap first-fit chunk allocator.
// Input stream: s_axis_tuser carries the operation (allocate, free, resize),
// s_axis_tdata the byte size and the held run. One result per transaction on
// the output stream: m_axis_tuser is the status, m_axis_tdata the run.
// The used-bit map sits in one RAM of 64-bit words, read-modify-written.
// One operation is in work at a time; s_axis_tready is high only when idle.
// Each transaction is decoded and finished; a first-fit scan tests the map
// bit-serially, one chunk at a time, fetching each map word as it reaches it,
// and marking or clearing a run reads and writes back each map word touched
// (checking an in-place extension only reads them). The bit-serial scan
// dominates the time for an allocation that searches the whole heap.
// The finished result sits in an output register; the next transaction is
// accepted while it waits, and a stalled receiver only holds the block once
// a second result is ready.
// Reset (i_rst_n low, synchronous) starts a clearing pass that writes zero to
// every map word, during which no transaction is accepted. Config writes
// (heap_chunks) are taken whenever reset is not held; they do not touch the
// map.
module bitmap_chunk_allocator_core #(
    parameter int MAX_CHUNKS   = bca_pkg::DEF_MAX_CHUNKS,
    parameter int CHUNK_BYTES  = bca_pkg::DEF_CHUNK_BYTES,
    parameter int HEADER_BYTES = bca_pkg::DEF_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [13:0] i_cfg_wr_data,  // heap_chunks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // size_bytes[20:0], run_start[33:21], run_length[47:34]
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_start[12:0], result_length[26:13], moved[27]
    output logic [1:0]  m_axis_tuser    // status
);
    localparam int IW    = bca_pkg::IDX_W;
    localparam int WBITS = bca_pkg::WORD_BITS;
    localparam int WB    = $clog2(WBITS);
    localparam int SH    = $clog2(CHUNK_BYTES);
    localparam int WORDS = (MAX_CHUNKS + WBITS - 1) / WBITS;
    localparam int WA    = $clog2(WORDS > 1 ? WORDS : 2);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DEC    = 8'b0000_0100,
        S_FF_RD  = 8'b0000_1000,
        S_FF_BIT = 8'b0001_0000,
        S_RG_RD  = 8'b0010_0000,
        S_RG_MOD = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {RM_CHECK, RM_SET, RM_CLR} t_rmode;
    typedef enum logic [1:0] {AF_FINISH, AF_CHECKED, AF_FREEOLD} t_after;

    t_state r_state, n_state;
    t_rmode r_rmode, n_rmode;
    t_after r_after, n_after;

    logic [bca_pkg::HEAP_W-1:0]  r_heap;
    logic [bca_pkg::KIND_W-1:0]  r_kind;
    logic [bca_pkg::SIZE_W-1:0]  r_size;
    logic [bca_pkg::START_W-1:0] r_rs;
    logic [bca_pkg::LEN_W-1:0]   r_rl;
    logic [IW-1:0] r_need, n_need;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_run, n_run;
    logic [IW-1:0] r_first, n_first;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [WA-1:0] r_wa, n_wa;
    logic [WA-1:0] r_clr, n_clr;
    logic          r_mvreq, n_mvreq;

    logic [bca_pkg::STATUS_W-1:0] r_st, n_st;
    logic [bca_pkg::START_W-1:0]  r_rst, n_rst;
    logic [bca_pkg::LEN_W-1:0]    r_rln, n_rln;
    logic                         r_mv, n_mv;

    logic                         r_ovalid, n_ovalid;
    logic [bca_pkg::STATUS_W-1:0] r_ost;
    logic [31:0]                  r_odata;
    logic                         w_oload;

    logic             w_we, w_re;
    logic [WA-1:0]    w_waddr, w_raddr;
    logic [WBITS-1:0] w_wdata, w_rdata, w_mask;

    logic [IW-1:0] w_hc, w_need, w_rsrl, w_clr_hi, w_wbase, w_wend, w_run1, w_first1;
    logic          w_bad, w_bit;

    bca_ram #(.WIDTH(WBITS), .DEPTH(WORDS)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_hc     = (IW'(r_heap) > IW'(MAX_CHUNKS)) ? IW'(MAX_CHUNKS) : IW'(r_heap);
    assign w_bad    = (r_size == '0) || ((32'(r_size)) > (32'(w_hc) << SH));
    assign w_need   = (IW'(r_size) + IW'(HEADER_BYTES + CHUNK_BYTES - 1)) >> SH;
    assign w_rsrl   = IW'(r_rs) + IW'(r_rl);
    assign w_clr_hi = (w_rsrl > w_hc) ? w_hc : w_rsrl;
    assign w_wbase  = IW'({r_wa, WB'(0)});
    assign w_wend   = w_wbase + IW'(WBITS);
    assign w_bit    = w_rdata[r_i[WB-1:0]];
    assign w_run1   = r_run + IW'(1);
    assign w_first1 = (r_run == '0) ? r_i : r_first;

    always_comb begin
        for (int b = 0; b < WBITS; b++) begin
            w_mask[b] = ((w_wbase + IW'(b)) >= r_lo) && ((w_wbase + IW'(b)) < r_hi);
        end
    end

    assign w_oload = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_rmode = r_rmode;
        n_after = r_after;
        n_need  = r_need;
        n_i     = r_i;
        n_run   = r_run;
        n_first = r_first;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_wa    = r_wa;
        n_clr   = r_clr;
        n_mvreq = r_mvreq;
        n_st    = r_st;
        n_rst   = r_rst;
        n_rln   = r_rln;
        n_mv    = r_mv;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_wa;
        w_raddr = r_wa;
        w_wdata = '0;
        n_ovalid = r_ovalid;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        if (w_oload) begin
            n_ovalid = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == WA'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + WA'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_st    = bca_pkg::ST_OK;
                n_rst   = '0;
                n_rln   = '0;
                n_mv    = 1'b0;
                n_need  = w_need;
                n_i     = '0;
                n_run   = '0;
                n_first = '0;
                n_mvreq = 1'b0;
                n_state = S_FIN;
                if (r_kind == bca_pkg::KIND_ALLOC ||
                    (r_kind == bca_pkg::KIND_RESIZE && r_rl == '0)) begin
                    if (w_bad) begin
                        n_st = bca_pkg::ST_SIZE;
                    end else if (w_need > w_hc) begin
                        n_st = bca_pkg::ST_NOSPACE;
                    end else begin
                        n_state = S_FF_RD;
                    end
                end else if (r_kind == bca_pkg::KIND_FREE) begin
                    if (r_rl == '0) begin
                        n_st = bca_pkg::ST_IGNORED;
                    end else if (IW'(r_rs) < w_clr_hi) begin
                        n_lo    = IW'(r_rs);
                        n_hi    = w_clr_hi;
                        n_wa    = WA'(IW'(r_rs) >> WB);
                        n_rmode = RM_CLR;
                        n_after = AF_FINISH;
                        n_state = S_RG_RD;
                    end
                end else if (r_kind == bca_pkg::KIND_RESIZE) begin
                    if (w_bad) begin
                        n_st = bca_pkg::ST_SIZE;
                    end else if (IW'(r_rl) >= w_need) begin
                        n_rst = r_rs;
                        n_rln = r_rl;
                    end else if ((IW'(r_rs) + w_need) > w_hc) begin
                        n_mvreq = 1'b1;
                        if (w_need > w_hc) begin
                            n_st = bca_pkg::ST_NOSPACE;
                        end else begin
                            n_state = S_FF_RD;
                        end
                    end else begin
                        n_lo    = w_rsrl;
                        n_hi    = IW'(r_rs) + w_need;
                        n_wa    = WA'(w_rsrl >> WB);
                        n_rmode = RM_CHECK;
                        n_after = AF_CHECKED;
                        n_state = S_RG_RD;
                    end
                end else begin
                    n_st = bca_pkg::ST_IGNORED;
                end
            end
            S_FF_RD: begin
                w_re    = 1'b1;
                w_raddr = WA'(r_i >> WB);
                n_state = S_FF_BIT;
            end
            S_FF_BIT: begin
                if (r_i >= w_hc) begin
                    n_st    = bca_pkg::ST_NOSPACE;
                    n_state = S_FIN;
                end else if (!w_bit && w_run1 == r_need) begin
                    // found: mark the new run, then free the old one on a move
                    n_st    = bca_pkg::ST_OK;
                    n_rst   = bca_pkg::START_W'(w_first1);
                    n_rln   = bca_pkg::LEN_W'(r_need);
                    n_mv    = r_mvreq;
                    n_lo    = w_first1;
                    n_hi    = w_first1 + r_need;
                    n_wa    = WA'(w_first1 >> WB);
                    n_rmode = RM_SET;
                    n_after = AF_FREEOLD;
                    n_state = S_RG_RD;
                end else begin
                    n_run   = w_bit ? '0 : w_run1;
                    n_first = w_bit ? r_first : w_first1;
                    n_i     = r_i + IW'(1);
                    if (n_i[WB-1:0] == '0) begin
                        n_state = S_FF_RD;
                    end
                end
            end
            S_RG_RD: begin
                w_re    = 1'b1;
                w_raddr = r_wa;
                n_state = S_RG_MOD;
            end
            S_RG_MOD: begin
                w_waddr = r_wa;
                case (r_rmode)
                    RM_SET:  begin w_we = 1'b1; w_wdata = w_rdata | w_mask;  end
                    RM_CLR:  begin w_we = 1'b1; w_wdata = w_rdata & ~w_mask; end
                    default: begin w_we = 1'b0; w_wdata = w_rdata;           end
                endcase
                if (r_rmode == RM_CHECK && (w_rdata & w_mask) != '0) begin
                    // extension blocked: look for a new run
                    n_mvreq = 1'b1;
                    n_i     = '0;
                    n_run   = '0;
                    n_first = '0;
                    n_state = S_FF_RD;
                end else if (w_wend < r_hi) begin
                    n_wa    = r_wa + WA'(1);
                    n_state = S_RG_RD;
                end else begin
                    n_state = S_FIN;
                    case (r_after)
                        AF_CHECKED: begin
                            n_st    = bca_pkg::ST_OK;
                            n_rst   = r_rs;
                            n_rln   = bca_pkg::LEN_W'(r_need);
                            n_wa    = WA'(w_rsrl >> WB);
                            n_rmode = RM_SET;
                            n_after = AF_FINISH;
                            n_state = S_RG_RD;
                        end
                        AF_FREEOLD: begin
                            if (r_mvreq && IW'(r_rs) < w_clr_hi) begin
                                n_lo    = IW'(r_rs);
                                n_hi    = w_clr_hi;
                                n_wa    = WA'(IW'(r_rs) >> WB);
                                n_rmode = RM_CLR;
                                n_after = AF_FINISH;
                                n_state = S_RG_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIN: begin
                if (w_oload) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_heap   <= bca_pkg::HEAP_W'(8192);
            r_rmode  <= RM_CHECK;
            r_after  <= AF_FINISH;
            r_mvreq  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_rmode  <= n_rmode;
            r_after  <= n_after;
            r_mvreq  <= n_mvreq;
            if (i_cfg_wr_en) begin
                r_heap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_size <= s_axis_tdata[20:0];
            r_rs   <= s_axis_tdata[33:21];
            r_rl   <= s_axis_tdata[47:34];
        end
        r_need  <= n_need;
        r_i     <= n_i;
        r_run   <= n_run;
        r_first <= n_first;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_wa    <= n_wa;
        r_st    <= n_st;
        r_rst   <= n_rst;
        r_rln   <= n_rln;
        r_mv    <= n_mv;
        if (w_oload) begin
            r_ost   <= r_st;
            r_odata <= {4'd0, r_mv, r_rln, r_rst};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ost;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !s_axis_tready)
        else $error("transaction accepted during map clear");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bca_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("error result carries nonzero run");

    a_map_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_RG_MOD || r_state == S_CLEAR))
        else $error("map written outside modify or clear");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_ovalid && !m_axis_tready |=> r_state == S_FIN)
        else $error("result dropped while receiver stalled");
endmodule

[verif/bca_checker.sv]
`timescale 1ns / 1ps

module bca_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [13:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int MAX_CH = bca_pkg::DEF_MAX_CHUNKS;
    localparam int CH_BYTES = bca_pkg::DEF_CHUNK_BYTES;
    localparam int HDR_BYTES = bca_pkg::DEF_HEADER_BYTES;

    typedef struct packed {
        logic [bca_pkg::STATUS_W-1:0] status;
        logic [bca_pkg::START_W-1:0]  start;
        logic [bca_pkg::LEN_W-1:0]    len;
        logic                         moved;
    } t_alloc_result;

    bit            chunk_used [MAX_CH];
    logic [13:0]   heap_reg;
    t_alloc_result pending_results [$];

    assign o_pending = pending_results.size();

    function automatic int unsigned heap_span();
        return (heap_reg > MAX_CH) ? MAX_CH : heap_reg;
    endfunction

    function automatic bit size_rejected(int unsigned size);
        return (size == 0) || (longint'(size) > longint'(heap_span()) * CH_BYTES);
    endfunction

    function automatic int unsigned chunks_for(int unsigned size);
        return (size + HDR_BYTES + CH_BYTES - 1) / CH_BYTES;
    endfunction

    function automatic bit take_first_fit(int unsigned need, output int unsigned start);
        int unsigned span, run, first;
        span = heap_span();
        run = 0;
        first = 0;
        start = 0;
        if (need == 0 || need > span) return 0;
        for (int unsigned i = 0; i < span; i++) begin
            if (chunk_used[i]) begin
                run = 0;
            end else begin
                if (run == 0) first = i;
                run++;
                if (run == need) begin
                    for (int unsigned k = first; k < first + need; k++) chunk_used[k] = 1;
                    start = first;
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic void release_run(int unsigned start, int unsigned len);
        int unsigned span;
        span = heap_span();
        for (int unsigned i = 0; i < len; i++)
            if (start + i < span) chunk_used[start + i] = 0;
    endfunction

    function automatic t_alloc_result make_res(logic [1:0] st, int unsigned s,
                                               int unsigned l, bit m);
        t_alloc_result r;
        r.status = st;
        r.start = s[bca_pkg::START_W-1:0];
        r.len = l[bca_pkg::LEN_W-1:0];
        r.moved = m;
        return r;
    endfunction

    function automatic t_alloc_result do_allocate(int unsigned size);
        int unsigned need, start;
        if (size_rejected(size)) return make_res(bca_pkg::ST_SIZE, 0, 0, 0);
        need = chunks_for(size);
        if (!take_first_fit(need, start)) return make_res(bca_pkg::ST_NOSPACE, 0, 0, 0);
        return make_res(bca_pkg::ST_OK, start, need, 0);
    endfunction

    function automatic t_alloc_result apply_op(logic [1:0] kind, int unsigned size,
                                               int unsigned rs, int unsigned rl);
        int unsigned need, span, ns;
        bit fits;
        case (kind)
            bca_pkg::KIND_ALLOC: return do_allocate(size);
            bca_pkg::KIND_FREE: begin
                if (rl == 0) return make_res(bca_pkg::ST_IGNORED, 0, 0, 0);
                release_run(rs, rl);
                return make_res(bca_pkg::ST_OK, 0, 0, 0);
            end
            bca_pkg::KIND_RESIZE: begin
                if (rl == 0) return do_allocate(size);
                if (size_rejected(size)) return make_res(bca_pkg::ST_SIZE, 0, 0, 0);
                need = chunks_for(size);
                if (rl >= need) return make_res(bca_pkg::ST_OK, rs, rl, 0);
                span = heap_span();
                fits = 1;
                for (int unsigned i = rs + rl; i < rs + need; i++) begin
                    if (i >= span) begin
                        fits = 0;
                        break;
                    end
                    if (chunk_used[i]) begin
                        fits = 0;
                        break;
                    end
                end
                if (fits) begin
                    for (int unsigned i = rs + rl; i < rs + need; i++) chunk_used[i] = 1;
                    return make_res(bca_pkg::ST_OK, rs, need, 0);
                end
                if (!take_first_fit(need, ns)) return make_res(bca_pkg::ST_NOSPACE, 0, 0, 0);
                release_run(rs, rl);
                return make_res(bca_pkg::ST_OK, ns, need, 1);
            end
            default: return make_res(bca_pkg::ST_IGNORED, 0, 0, 0);
        endcase
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_alloc_result want, got;
        if (!i_rst_n) begin
            foreach (chunk_used[i]) chunk_used[i] = 0;
            heap_reg = 14'd8192;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) heap_reg = i_cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.start = m_axis_tdata[12:0];
                got.len = m_axis_tdata[26:13];
                got.moved = m_axis_tdata[27];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d start=%0d len=%0d moved=%0d",
                             $time, got.status, got.start, got.len, got.moved);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected status=%0d start=%0d len=%0d moved=%0d",
                                 $time, want.status, want.start, want.len, want.moved);
                        $display("%0t:          actual   status=%0d start=%0d len=%0d moved=%0d",
                                 $time, got.status, got.start, got.len, got.moved);
                        o_fail_count++;
                    end
                end
            end
            // dut handles one op at a time, in order, so predicting at accept is exact
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_op(s_axis_tuser, s_axis_tdata[20:0],
                                                   s_axis_tdata[33:21], s_axis_tdata[47:34]));
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    localparam logic [bca_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [13:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // size_bytes[20:0], run_start[33:21], run_length[47:34]
    logic [1:0]  s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // result_start[12:0], result_length[26:13], moved[27]
    logic [1:0]  m_axis_tuser;   // status
    int          fail_count;
    int          pending;

    int unsigned heap_now;
    int          ops_sent;
    int          stall_left;
    bit          quiet;

    bitmap_chunk_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bca_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random backpressure plus an optional long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    task automatic send_op(logic [1:0] kind, int unsigned size, int unsigned rs,
                           int unsigned rl);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {rl[13:0], rs[12:0], size[20:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        ops_sent++;
    endtask

    task automatic set_heap(int unsigned chunks);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= chunks[13:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        heap_now = (chunks > bca_pkg::DEF_MAX_CHUNKS) ? bca_pkg::DEF_MAX_CHUNKS : chunks;
    endtask

    task automatic random_op();
        int unsigned r, sz, rs, rl, top;
        r = $urandom_range(99);
        top = (heap_now == 0) ? 1 : heap_now;
        if ($urandom_range(99) < 80) sz = $urandom_range(1, top * 32);
        else if ($urandom_range(99) < 75)
            sz = $urandom_range(1, top * bca_pkg::DEF_CHUNK_BYTES + 200);
        else sz = 0;
        rs = $urandom_range(0, top - 1);
        rl = $urandom_range(1, 8);
        if (r < 45) begin
            send_op(bca_pkg::KIND_ALLOC, sz, $urandom, $urandom);
        end else if (r < 65) begin
            send_op(bca_pkg::KIND_FREE, 0, rs, rl);
        end else if (r < 85) begin
            // mostly modest growth so in-place extension gets a chance
            send_op(bca_pkg::KIND_RESIZE, $urandom_range(1, rl * 256), rs, rl);
        end else begin
            send_op(2'($urandom_range(0, 3)), ($urandom_range(9) == 0) ? 0 : $urandom,
                    $urandom, $urandom_range(9) == 0 ? 0 : $urandom);
        end
    endtask

    initial begin
        int unsigned heaps [6] = '{64, 200, 512, 37, 1, 8192};
        int          counts [6] = '{300, 280, 260, 280, 120, 40};
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        heap_now = bca_pkg::DEF_MAX_CHUNKS;
        ops_sent = 0;
        stall_left = 0;
        quiet = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full reset heap
        send_op(bca_pkg::KIND_ALLOC, 0, 0, 0);
        send_op(bca_pkg::KIND_ALLOC, 1, 0, 0);
        send_op(bca_pkg::KIND_ALLOC, 112, 0, 0);          // exactly one chunk with header
        send_op(bca_pkg::KIND_ALLOC, 113, 0, 0);          // spills into a second chunk
        send_op(bca_pkg::KIND_ALLOC, 1048576, 0, 0);      // one chunk more than the heap
        send_op(bca_pkg::KIND_ALLOC, 1048577, 0, 0);
        send_op(bca_pkg::KIND_ALLOC, 21'h1FFFFF, 13'h1FFF, 14'h3FFF);
        send_op(bca_pkg::KIND_FREE, 0, 3, 0);             // nothing held
        send_op(KIND_UNUSED, 500, 5, 5);
        send_op(bca_pkg::KIND_RESIZE, 300, 0, 0);         // behaves as allocate
        send_op(bca_pkg::KIND_RESIZE, 100, 0, 1);         // already big enough
        send_op(bca_pkg::KIND_RESIZE, 600, 6, 3);         // grow into free chunks
        send_op(bca_pkg::KIND_RESIZE, 600, 0, 1);         // blocked, moves
        send_op(bca_pkg::KIND_RESIZE, 0, 2, 2);
        send_op(bca_pkg::KIND_FREE, 0, 8191, 14'h3FFF);   // mostly beyond the heap
        send_op(bca_pkg::KIND_RESIZE, 1000, 8190, 2);     // extension would leave the heap
        send_op(bca_pkg::KIND_FREE, 0, 0, 8192);
        send_op(bca_pkg::KIND_ALLOC, 1048560, 0, 0);      // takes the whole heap
        send_op(bca_pkg::KIND_RESIZE, 400, 0, 8192);
        send_op(bca_pkg::KIND_ALLOC, 1, 0, 0);            // no space
        send_op(bca_pkg::KIND_RESIZE, 500, 100, 1);       // no space, old run kept
        send_op(bca_pkg::KIND_FREE, 0, 0, 8192);
        set_heap(16383);                                  // clipped to the map size
        send_op(bca_pkg::KIND_ALLOC, 1048560, 0, 0);
        send_op(bca_pkg::KIND_FREE, 0, 0, 8192);
        set_heap(1);
        send_op(bca_pkg::KIND_ALLOC, 112, 0, 0);
        send_op(bca_pkg::KIND_ALLOC, 113, 0, 0);
        send_op(bca_pkg::KIND_RESIZE, 200, 0, 1);

        for (int p = 0; p < 6; p++) begin
            set_heap(heaps[p]);
            for (int n = 0; n < counts[p]; n++) begin
                if (p == 0 && n == 50) stall_left = 600;
                quiet = (p == 1 && n >= 100 && n < 200);
                random_op();
            end
            quiet = 0;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("ran %0d transactions: allocate, free, resize and unused kinds", ops_sent);
        $display("heap sizes 1 to 8192 plus a clipped setting, with stalls and a long hold-off");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
